@@ design/rosn_pkg.sv @@
// ----------------------------------------------------------------------------
// rosn_pkg
// Shared types and constants of the range outlier smooth/normalize block
// ----------------------------------------------------------------------------
package rosn_pkg;

    // input sample width default
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int CFG_W    = 16;                 // distance registers
    localparam int FRAC_W   = 8;                  // Q.8 fraction of the average
    localparam int LEVEL_W  = 16;                 // Q0.16 level
    localparam int BAD_W    = 16;                 // bad-read counter
    localparam int RUN_W    = 4;                  // jump run counter / limit
    localparam int WEIGHT_W = 8;                  // smoothing weight
    localparam int STAT_W   = 2;                  // result status
    localparam int DIV_W    = CFG_W + FRAC_W;     // divider operand width
    localparam int OUT_DW   = LEVEL_W + CFG_W + BAD_W;

    // configuration port
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REGIX_W = ADDR_W - 2;

    typedef logic [REGIX_W-1:0] t_reg_idx;
    typedef logic [STAT_W-1:0]  t_status;

    localparam t_reg_idx REG_ENABLE    = 3'd0;
    localparam t_reg_idx REG_MIN_DIST  = 3'd1;
    localparam t_reg_idx REG_MAX_DIST  = 3'd2;
    localparam t_reg_idx REG_THRESHOLD = 3'd3;
    localparam t_reg_idx REG_RUN_LIMIT = 3'd4;
    localparam t_reg_idx REG_FILTER_ON = 3'd5;
    localparam t_reg_idx REG_WEIGHT    = 3'd6;

    // register reset values
    localparam logic                RST_ENABLE    = 1'b1;
    localparam logic [CFG_W-1:0]    RST_MIN_DIST  = 16'd0;
    localparam logic [CFG_W-1:0]    RST_MAX_DIST  = 16'hFFFF;
    localparam logic [CFG_W-1:0]    RST_THRESHOLD = 16'hFFFF;
    localparam logic [RUN_W-1:0]    RST_RUN_LIMIT = 4'd3;
    localparam logic                RST_FILTER_ON = 1'b1;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 8'd230;

    // status codes
    localparam t_status ST_ACCEPTED = 2'd0;
    localparam t_status ST_BAD_READ = 2'd1;
    localparam t_status ST_REJECTED = 2'd2;
    localparam t_status ST_DISABLED = 2'd3;

    localparam logic [LEVEL_W-1:0]  LEVEL_ONE  = 16'hFFFF;
    localparam logic [BAD_W-1:0]    BAD_MAX    = 16'hFFFF;
    localparam logic [WEIGHT_W:0]   WEIGHT_ONE = 9'd256;
    localparam logic [FRAC_W:0]     ROUND_HALF = 9'd128;

endpackage

@@ design/rosn_div.sv @@
// ----------------------------------------------------------------------------
// rosn_div
// Restoring divider for the level: quot = floor(num * 65535 / den),
// one quotient bit a cycle, requires num < den
// ----------------------------------------------------------------------------
module rosn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rosn_pkg::DIV_W-1:0]  i_num,
    input  logic [rosn_pkg::DIV_W-1:0]  i_den,
    output logic                        o_done,
    output logic [rosn_pkg::LEVEL_W-1:0] o_quot
);
    import rosn_pkg::*;

    localparam int NUM_W = DIV_W + LEVEL_W;
    localparam int CNT_W = $clog2(LEVEL_W + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_den, n_den;
    logic [LEVEL_W-1:0]   r_shift, n_shift;

    logic [NUM_W-1:0]     scaled;
    logic [DIV_W:0]       cand;
    logic [DIV_W+1:0]     diff;
    logic                 ge;

    // num * (2^16 - 1); the high part is below den since num < den
    assign scaled = {i_num, {LEVEL_W{1'b0}}} - NUM_W'(i_num);
    assign cand   = {r_rem, r_shift[LEVEL_W-1]};
    assign diff   = {1'b0, cand} - {2'b00, r_den};
    assign ge     = ~diff[DIV_W+1];

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_shift = r_shift;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_W'(LEVEL_W);
            n_rem   = scaled[NUM_W-1:LEVEL_W];
            n_shift = scaled[LEVEL_W-1:0];
            n_den   = i_den;
        end else if (r_busy) begin
            n_rem   = ge ? diff[DIV_W-1:0] : cand[DIV_W-1:0];
            n_shift = {r_shift[LEVEL_W-2:0], ge};
            n_cnt   = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_shift <= n_shift;
    end

    assign o_done = r_done;
    assign o_quot = r_shift;

endmodule

@@ design/range_outlier_smooth_normalize.sv @@
// ----------------------------------------------------------------------------
// range_outlier_smooth_normalize
// Distance smoother with jump rejection and span normalization
// ----------------------------------------------------------------------------
// One reading is taken at a time. A failed, rejected or disabled reading
// passes from its transfer through the done state into the output register.
// An accepted reading whose average lies strictly inside the span takes two
// passes through the shared multiplier for the exponential average, a span
// compare that loads the bit-serial divider, sixteen divider steps, a state
// that takes the Q0.16 quotient and the fill of the output register. An
// accepted reading with a clamped level or an empty span skips the divider.
// The input accepts the next reading as soon as the result sits in the output
// register, even while that result waits for the downstream side.
module range_outlier_smooth_normalize #(
    parameter int SAMPLE_WIDTH = rosn_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,   // distance
    input  logic                                s_axis_tuser,   // read_ok
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rosn_pkg::OUT_DW-1:0]         m_axis_tdata,   // level, smoothed_distance, bad_reads
    output logic [rosn_pkg::STAT_W-1:0]         m_axis_tuser,   // status
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rosn_pkg::ADDR_W-1:0]         paddr,
    input  logic [rosn_pkg::DATA_W-1:0]         pwdata,
    output logic [rosn_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import rosn_pkg::*;

    localparam int AW    = SAMPLE_WIDTH + FRAC_W;
    localparam int CW    = (AW > DIV_W) ? AW : DIV_W;
    localparam int TW    = (SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W;
    localparam int MA_W  = WEIGHT_W + 1;
    localparam int PR_W  = AW + MA_W;
    localparam int ACC_W = PR_W + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL_OLD = 3'd1;
    localparam logic [2:0] S_MUL_NEW = 3'd2;
    localparam logic [2:0] S_LEVEL   = 3'd3;
    localparam logic [2:0] S_DIV     = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    // configuration registers
    logic                   r_enable;
    logic [CFG_W-1:0]       r_min, r_max, r_thresh;
    logic [RUN_W-1:0]       r_limit;
    logic                   r_filt;
    logic [WEIGHT_W-1:0]    r_weight;

    // block state
    logic [2:0]             r_state, n_state;
    logic [SAMPLE_WIDTH-1:0] r_prev, n_prev;
    logic [AW-1:0]          r_avg, n_avg;
    logic [LEVEL_W-1:0]     r_norm, n_norm;
    logic [RUN_W-1:0]       r_run, n_run;
    logic [BAD_W-1:0]       r_bad, n_bad;
    t_status                r_status, n_status;
    logic [SAMPLE_WIDTH-1:0] r_dist, n_dist;
    logic [ACC_W-1:0]       r_acc, n_acc;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [OUT_DW-1:0]      r_out_data, n_out_data;
    t_status                r_out_status, n_out_status;

    logic                   cfg_wr;
    t_reg_idx               reg_idx;
    logic                   in_xfer;
    logic                   out_free;
    logic [SAMPLE_WIDTH-1:0] in_dist;
    logic [SAMPLE_WIDTH-1:0] delta;
    logic [RUN_W:0]         run_inc;
    logic                   is_jump;

    logic [MA_W-1:0]        mul_a;
    logic [AW-1:0]          mul_b;
    logic [PR_W-1:0]        mul_p;
    logic [ACC_W-1:0]       acc_sum;

    logic [CW-1:0]          avg_x, lo_x, hi_x, num_x, den_x;
    logic                   div_start, div_done;
    logic [LEVEL_W-1:0]     div_quot;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= RST_ENABLE;
            r_min    <= RST_MIN_DIST;
            r_max    <= RST_MAX_DIST;
            r_thresh <= RST_THRESHOLD;
            r_limit  <= RST_RUN_LIMIT;
            r_filt   <= RST_FILTER_ON;
            r_weight <= RST_WEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ENABLE:    r_enable <= pwdata[0];
                REG_MIN_DIST:  r_min    <= pwdata[CFG_W-1:0];
                REG_MAX_DIST:  r_max    <= pwdata[CFG_W-1:0];
                REG_THRESHOLD: r_thresh <= pwdata[CFG_W-1:0];
                REG_RUN_LIMIT: r_limit  <= pwdata[RUN_W-1:0];
                REG_FILTER_ON: r_filt   <= pwdata[0];
                REG_WEIGHT:    r_weight <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENABLE:    prdata = DATA_W'(r_enable);
            REG_MIN_DIST:  prdata = DATA_W'(r_min);
            REG_MAX_DIST:  prdata = DATA_W'(r_max);
            REG_THRESHOLD: prdata = DATA_W'(r_thresh);
            REG_RUN_LIMIT: prdata = DATA_W'(r_limit);
            REG_FILTER_ON: prdata = DATA_W'(r_filt);
            REG_WEIGHT:    prdata = DATA_W'(r_weight);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_out_valid | m_axis_tready;
    assign in_dist       = s_axis_tdata[SAMPLE_WIDTH-1:0];

    assign delta   = (in_dist >= r_prev) ? (in_dist - r_prev) : (r_prev - in_dist);
    assign run_inc = {1'b0, r_run} + (RUN_W+1)'(1);
    assign is_jump = r_filt & (TW'(delta) > TW'(r_thresh));

    // shared multiplier: old average by weight, then new sample by its complement
    always_comb begin
        if (r_state == S_MUL_NEW) begin
            mul_a = WEIGHT_ONE - {1'b0, r_weight};
            mul_b = {r_dist, {FRAC_W{1'b0}}};
        end else begin
            mul_a = {1'b0, r_weight};
            mul_b = r_avg;
        end
    end
    assign mul_p   = mul_a * mul_b;
    assign acc_sum = r_acc + ACC_W'(mul_p);

    assign avg_x = CW'(r_avg);
    assign lo_x  = CW'({r_min, {FRAC_W{1'b0}}});
    assign hi_x  = CW'({r_max, {FRAC_W{1'b0}}});
    assign num_x = avg_x - lo_x;
    assign den_x = hi_x - lo_x;

    assign div_start = (r_state == S_LEVEL) && (r_max > r_min) &&
                       (avg_x > lo_x) && (avg_x < hi_x);

    rosn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_x[DIV_W-1:0]),
        .i_den   (den_x[DIV_W-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_avg        = r_avg;
        n_norm       = r_norm;
        n_run        = r_run;
        n_bad        = r_bad;
        n_status     = r_status;
        n_dist       = r_dist;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid & ~m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_dist = in_dist;
                    if (!r_enable) begin
                        n_status = ST_DISABLED;
                        n_state  = S_DONE;
                    end else if (!s_axis_tuser) begin
                        if (r_bad != BAD_MAX) begin
                            n_bad = r_bad + BAD_W'(1);
                        end
                        n_status = ST_BAD_READ;
                        n_state  = S_DONE;
                    end else begin
                        n_prev = in_dist;
                        if (is_jump && (run_inc <= {1'b0, r_limit})) begin
                            n_run    = run_inc[RUN_W-1:0];
                            n_status = ST_REJECTED;
                            n_state  = S_DONE;
                        end else begin
                            n_run    = '0;
                            n_bad    = '0;
                            n_status = ST_ACCEPTED;
                            n_state  = S_MUL_OLD;
                        end
                    end
                end
            end
            S_MUL_OLD: begin
                n_acc   = ACC_W'(mul_p) + ACC_W'(ROUND_HALF);
                n_state = S_MUL_NEW;
            end
            S_MUL_NEW: begin
                n_avg   = acc_sum[AW+FRAC_W-1:FRAC_W];
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                if (div_start) begin
                    n_state = S_DIV;
                end else begin
                    // empty span or average at or below the minimum gives zero, at or above the maximum gives one
                    if ((r_max > r_min) && (avg_x >= hi_x)) begin
                        n_norm = LEVEL_ONE;
                    end else begin
                        n_norm = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_norm  = div_quot;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = {r_bad, avg_x[FRAC_W+CFG_W-1:FRAC_W], r_norm};
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_avg       <= '0;
            r_norm      <= '0;
            r_run       <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_avg       <= n_avg;
            r_norm      <= n_norm;
            r_run       <= n_run;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_dist       <= n_dist;
        r_acc        <= n_acc;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule
